>>> rtl/p2par_pkg.sv
// Shared constants and unit handshake types for the pixel-to-picture aspect ratio block.
// Used by the GCD unit, the divider and the top-level sequencer. No dependencies.
package p2par_pkg;

    localparam int DATA_W     = 32;               // working width of all ratio members
    localparam int FIELD_W    = 31;               // width of each input field
    localparam int LIMIT_BITS = 16;               // members are halved until they fit here
    localparam int PROD_W     = 2 * LIMIT_BITS;   // full width of a crosswise product
    localparam int SHIFT_W    = $clog2(DATA_W);   // common power-of-two count in the GCD

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } gcd_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] g;
    } gcd_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
    } div_rsp_t;

endpackage

>>> rtl/p2par_gcd.sv
// Iterative binary GCD unit: one shift or one subtract-and-shift per cycle.
// Depends on p2par_pkg. GCD(a,0) = a and GCD(0,0) = 0.
module p2par_gcd (
    input  logic                aclk,
    input  logic                aresetn,
    input  p2par_pkg::gcd_req_t req,
    output p2par_pkg::gcd_rsp_t rsp
);

    logic [p2par_pkg::DATA_W-1:0]  a_reg, a_next;
    logic [p2par_pkg::DATA_W-1:0]  b_reg, b_next;
    logic [p2par_pkg::SHIFT_W-1:0] k_reg, k_next;
    logic [p2par_pkg::DATA_W-1:0]  g_reg, g_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [p2par_pkg::DATA_W-1:0]  big, little, diff;

    always_comb begin
        big    = (a_reg >= b_reg) ? a_reg : b_reg;
        little = (a_reg >= b_reg) ? b_reg : a_reg;
        diff   = big - little;

        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            a_next    = req.a;
            b_next    = req.b;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            priority if (a_reg == '0) begin
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (b_reg == '0) begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!a_reg[0] && !b_reg[0]) begin
                // common factor of two: pull it out and count it
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else begin
                // both odd: difference is even, replace the larger one
                if (a_reg >= b_reg) begin
                    a_next = diff >> 1;
                end else begin
                    b_next = diff >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign rsp.done = done_reg;
    assign rsp.g    = g_reg;

endmodule

>>> rtl/p2par_div.sv
// Restoring radix-2 divider: one quotient bit per cycle.
// Depends on p2par_pkg. The divisor must be nonzero.
module p2par_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  p2par_pkg::div_req_t req,
    output p2par_pkg::div_rsp_t rsp
);

    logic [p2par_pkg::DATA_W-1:0]   rem_reg, rem_next;
    logic [p2par_pkg::DATA_W-1:0]   quo_reg, quo_next;
    logic [p2par_pkg::DATA_W-1:0]   den_reg, den_next;
    logic [p2par_pkg::SHIFT_W-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [p2par_pkg::DATA_W:0]     trial;
    logic [p2par_pkg::DATA_W:0]     sub;

    always_comb begin
        trial = {rem_reg, quo_reg[p2par_pkg::DATA_W-1]};
        sub   = trial - {1'b0, den_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // dividend bits shift out of the top of quo_reg as quotient bits shift in
            if (!sub[p2par_pkg::DATA_W]) begin
                rem_next = sub[p2par_pkg::DATA_W-1:0];
                quo_next = {quo_reg[p2par_pkg::DATA_W-2:0], 1'b1};
            end else begin
                rem_next = trial[p2par_pkg::DATA_W-1:0];
                quo_next = {quo_reg[p2par_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> rtl/pixel_to_picture_aspect_ratio_top.sv
// Pixel aspect ratio to picture aspect ratio: sequencer around a shared GCD unit,
// a shared divider and one narrow multiplier. Depends on p2par_pkg, p2par_gcd, p2par_div.
//
// Each input transaction (frame width, frame height, pixel ratio x:y) yields one
// output transaction with the picture aspect ratio in lowest terms; any zero input
// gives 0:0. The block takes one item at a time and holds s_tready low until the result
// has moved into the output register, which can still be waiting on m_tready while the
// next item is accepted. An item passes three reductions, each a binary GCD (one step
// per cycle) followed by two divisions on the shared divider, plus halving in S_LIMIT
// and the two multiplies in S_MULX and S_MULY.
module pixel_to_picture_aspect_ratio_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [30:0] frame_width, [61:31] frame_height, [92:62] pixel_ratio_x,
    // [123:93] pixel_ratio_y, [127:124] zero
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] picture_ratio_x, [63:32] picture_ratio_y
    output logic [63:0]  m_tdata
);

    localparam int DataW  = p2par_pkg::DATA_W;
    localparam int FieldW = p2par_pkg::FIELD_W;
    localparam int LimW   = p2par_pkg::LIMIT_BITS;
    localparam int ProdW  = p2par_pkg::PROD_W;

    localparam logic [1:0] PASS_FRAME   = 2'd0;
    localparam logic [1:0] PASS_PIXEL   = 2'd1;
    localparam logic [1:0] PASS_PICTURE = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_GSTART = 10'b00_0000_0010,
        S_GWAIT  = 10'b00_0000_0100,
        S_DSTART = 10'b00_0000_1000,
        S_DIVA   = 10'b00_0001_0000,
        S_DIVB   = 10'b00_0010_0000,
        S_LIMIT  = 10'b00_0100_0000,
        S_MULX   = 10'b00_1000_0000,
        S_MULY   = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          pass_reg, pass_next;
    logic [DataW-1:0]    w_reg, w_next;
    logic [DataW-1:0]    h_reg, h_next;
    logic [DataW-1:0]    px_reg, px_next;
    logic [DataW-1:0]    py_reg, py_next;
    logic [DataW-1:0]    g_reg, g_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [63:0]         m_tdata_reg, m_tdata_next;

    p2par_pkg::gcd_req_t gcd_req;
    p2par_pkg::gcd_rsp_t gcd_rsp;
    p2par_pkg::div_req_t div_req;
    p2par_pkg::div_rsp_t div_rsp;

    logic [FieldW-1:0]   in_w, in_h, in_px, in_py;
    logic                in_zero;
    logic                s_accept;
    logic                out_free;
    logic [DataW-1:0]    pair_a, pair_b;
    logic                wh_over, pp_over;
    logic [LimW-1:0]     mul_a, mul_b;
    logic [ProdW-1:0]    prod;
    logic [DataW-1:0]    prod_lo;

    assign in_w  = s_tdata[FieldW-1:0];
    assign in_h  = s_tdata[2*FieldW-1:FieldW];
    assign in_px = s_tdata[3*FieldW-1:2*FieldW];
    assign in_py = s_tdata[4*FieldW-1:3*FieldW];
    assign in_zero = (in_w == '0) || (in_h == '0) || (in_px == '0) || (in_py == '0);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // pixel pass works on x:y, the frame and picture passes on the w:h registers
    assign pair_a = (pass_reg == PASS_PIXEL) ? px_reg : w_reg;
    assign pair_b = (pass_reg == PASS_PIXEL) ? py_reg : h_reg;

    assign wh_over = (w_reg[DataW-1:LimW] != '0) || (h_reg[DataW-1:LimW] != '0);
    assign pp_over = (px_reg[DataW-1:LimW] != '0) || (py_reg[DataW-1:LimW] != '0);

    assign mul_a   = (state_reg == S_MULY) ? py_reg[LimW-1:0] : px_reg[LimW-1:0];
    assign mul_b   = (state_reg == S_MULY) ? h_reg[LimW-1:0] : w_reg[LimW-1:0];
    assign prod    = ProdW'(mul_a) * ProdW'(mul_b);
    assign prod_lo = DataW'(prod);

    always_comb begin
        gcd_req.start = (state_reg == S_GSTART);
        gcd_req.a     = pair_a;
        gcd_req.b     = pair_b;

        div_req.start = (state_reg == S_DSTART) || ((state_reg == S_DIVA) && div_rsp.done);
        div_req.num   = (state_reg == S_DSTART) ? pair_a : pair_b;
        div_req.den   = g_reg;
    end

    p2par_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (gcd_req),
        .rsp     (gcd_rsp)
    );

    p2par_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        g_next        = g_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    pass_next = PASS_FRAME;
                    px_next   = DataW'(in_px);
                    py_next   = DataW'(in_py);
                    if (in_zero) begin
                        w_next     = '0;
                        h_next     = '0;
                        state_next = S_OUT;
                    end else begin
                        w_next     = DataW'(in_w);
                        h_next     = DataW'(in_h);
                        state_next = S_GSTART;
                    end
                end
            end
            S_GSTART: begin
                state_next = S_GWAIT;
            end
            S_GWAIT: begin
                if (gcd_rsp.done) begin
                    g_next = gcd_rsp.g;
                    // zero GCD only when both products are zero: pass 0:0 on
                    state_next = (gcd_rsp.g == '0) ? S_OUT : S_DSTART;
                end
            end
            S_DSTART: begin
                state_next = S_DIVA;
            end
            S_DIVA: begin
                if (div_rsp.done) begin
                    if (pass_reg == PASS_PIXEL) begin
                        px_next = div_rsp.quo;
                    end else begin
                        w_next = div_rsp.quo;
                    end
                    state_next = S_DIVB;
                end
            end
            S_DIVB: begin
                if (div_rsp.done) begin
                    if (pass_reg == PASS_PIXEL) begin
                        py_next = div_rsp.quo;
                    end else begin
                        h_next = div_rsp.quo;
                    end
                    priority case (pass_reg)
                        PASS_FRAME: begin
                            pass_next  = PASS_PIXEL;
                            state_next = S_GSTART;
                        end
                        PASS_PIXEL: state_next = S_LIMIT;
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_LIMIT: begin
                // halve each pair together until both members fit
                if (wh_over) begin
                    w_next = w_reg >> 1;
                    h_next = h_reg >> 1;
                end
                if (pp_over) begin
                    px_next = px_reg >> 1;
                    py_next = py_reg >> 1;
                end
                if (!wh_over && !pp_over) begin
                    state_next = S_MULX;
                end
            end
            S_MULX: begin
                w_next     = prod_lo;
                state_next = S_MULY;
            end
            S_MULY: begin
                h_next     = prod_lo;
                pass_next  = PASS_PICTURE;
                state_next = S_GSTART;
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {h_reg, w_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pass_reg     <= PASS_FRAME;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        w_reg       <= w_next;
        h_reg       <= h_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        g_reg       <= g_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one item at a time: an accepted transaction closes the input side
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // a zero member skips the arithmetic and goes straight to the output stage
    a_zero_shortcut: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && in_zero |=> state_reg == S_OUT)
        else $error("zero input did not take the short path");

    // a new result appears only from the output stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output stage");

    // the two shared units are never started in the same cycle
    a_unit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !(gcd_req.start && div_req.start))
        else $error("GCD and divider started together");

endmodule
